>>> design/yuv2rgb_pkg.sv
package yuv2rgb_pkg;

    localparam int COEF_BITS   = 12;
    localparam int ROW_W       = 3 * COEF_BITS;
    localparam int SAMPLE_W    = 9;
    localparam int PROD_W      = COEF_BITS + SAMPLE_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 9;
    localparam int ROUND_BIAS  = 256;
    localparam int LUMA_BIAS   = 16;
    localparam int CHROMA_BIAS = 128;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_ROW    = 3'd0,
        CFG_GREEN_ROW  = 3'd1,
        CFG_BLUE_ROW   = 3'd2,
        CFG_LUMA_OFS   = 3'd3,
        CFG_OUT_FORMAT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        FMT_BGRA8888 = 1'b0,
        FMT_RGB565   = 1'b1
    } t_out_format;

    // One matrix row applied to a pixel, rounded, floored and clamped to 0..255.
    function automatic logic [7:0] f_channel(
        input logic [ROW_W-1:0]           row,
        input logic signed [SAMPLE_W-1:0] y,
        input logic signed [SAMPLE_W-1:0] u,
        input logic signed [SAMPLE_W-1:0] v
    );
        logic signed [COEF_BITS-1:0] c_y;
        logic signed [COEF_BITS-1:0] c_u;
        logic signed [COEF_BITS-1:0] c_v;
        logic signed [SUM_W-1:0]     t;
        logic [7:0]                  q;
        c_y = signed'(row[COEF_BITS-1:0]);
        c_u = signed'(row[2*COEF_BITS-1:COEF_BITS]);
        c_v = signed'(row[3*COEF_BITS-1:2*COEF_BITS]);
        t = SUM_W'(c_y) * SUM_W'(y) + SUM_W'(c_u) * SUM_W'(u)
          + SUM_W'(c_v) * SUM_W'(v) + SUM_W'(ROUND_BIAS);
        if (t[SUM_W-1]) begin
            q = 8'd0;
        end else if (|t[SUM_W-2:FRAC_SHIFT+8]) begin
            q = 8'hff;
        end else begin
            q = t[FRAC_SHIFT+7:FRAC_SHIFT];
        end
        return q;
    endfunction

endpackage

>>> design/yuv_to_rgb_color_converter.sv
// Per-pixel YCbCr to RGB converter. One pixel (Y, U, V bytes) enters per clock while the
// output side is not stalled; it is held in the input register, and its result in the
// result register, with the nine coefficient products, the rounding sum, the clamp and
// the packing in between. Chroma is re-centered by 128 and luma optionally by 16, the
// programmed 3x3 matrix (signed coefficients, 9 fraction bits) is applied, and each
// channel is clamped to 0..255. The packed word is BGRA8888 with opaque alpha or RGB565
// in the low half. Registers are written through the config channel, which is always
// ready; the user must write them only while the stream is idle, as the block itself
// does not enforce this.
module yuv_to_rgb_color_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Config write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [yuv2rgb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [yuv2rgb_pkg::ROW_W-1:0]        i_cfg_data,
    // Pixel input stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [yuv2rgb_pkg::IN_DATA_W-1:0]    i_s_tdata,  // luma, chroma_u, chroma_v
    // Result stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [yuv2rgb_pkg::OUT_DATA_W-1:0]   o_m_tdata   // packed_pixel, red, green, blue
);
    import yuv2rgb_pkg::*;

    logic [ROW_W-1:0]  r_coef_red;
    logic [ROW_W-1:0]  r_coef_green;
    logic [ROW_W-1:0]  r_coef_blue;
    logic              r_luma_ofs;
    t_out_format       r_out_format;

    logic              r_in_valid;
    logic [7:0]        r_luma;
    logic [7:0]        r_chroma_u;
    logic [7:0]        r_chroma_v;

    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              advance;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] u;
    logic signed [SAMPLE_W-1:0] v;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [31:0]       packed_pixel;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_red   <= '0;
            r_coef_green <= '0;
            r_coef_blue  <= '0;
            r_luma_ofs   <= 1'b0;
            r_out_format <= FMT_BGRA8888;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RED_ROW:    r_coef_red   <= i_cfg_data;
                CFG_GREEN_ROW:  r_coef_green <= i_cfg_data;
                CFG_BLUE_ROW:   r_coef_blue  <= i_cfg_data;
                CFG_LUMA_OFS:   r_luma_ofs   <= i_cfg_data[0];
                CFG_OUT_FORMAT: r_out_format <= t_out_format'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // The result register moves whenever it is empty or being drained; the input
    // register may fill whenever it is empty or its item moves on.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_luma     <= i_s_tdata[7:0];
            r_chroma_u <= i_s_tdata[15:8];
            r_chroma_v <= i_s_tdata[23:16];
        end
    end

    always_comb begin
        y = signed'({1'b0, r_luma}) - (r_luma_ofs ? SAMPLE_W'(LUMA_BIAS) : SAMPLE_W'(0));
        u = signed'({1'b0, r_chroma_u}) - SAMPLE_W'(CHROMA_BIAS);
        v = signed'({1'b0, r_chroma_v}) - SAMPLE_W'(CHROMA_BIAS);
        red   = f_channel(r_coef_red,   y, u, v);
        green = f_channel(r_coef_green, y, u, v);
        blue  = f_channel(r_coef_blue,  y, u, v);
        unique case (r_out_format)
            FMT_RGB565:   packed_pixel = {16'd0, red[7:3], green[7:2], blue[7:3]};
            FMT_BGRA8888: packed_pixel = {ALPHA_OPAQUE, red, green, blue};
            default:      packed_pixel = {ALPHA_OPAQUE, red, green, blue};
        endcase
        n_out_data = {blue, green, red, packed_pixel};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/yuv2rgb_checker.sv
module yuv2rgb_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_s_tready,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [yuv2rgb_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import yuv2rgb_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Input is held off only while a finished result is being stalled.
    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output backpressure");

    // A stalled result holds.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // The packed word agrees with the channel fields in either format.
    a_pack_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ((o_m_tdata[31:24] == ALPHA_OPAQUE && o_m_tdata[23:16] == o_m_tdata[39:32]
              && o_m_tdata[15:8] == o_m_tdata[47:40] && o_m_tdata[7:0] == o_m_tdata[55:48])
          || (o_m_tdata[31:16] == 16'd0 && o_m_tdata[15:11] == o_m_tdata[39:35]
              && o_m_tdata[10:5] == o_m_tdata[47:42] && o_m_tdata[4:0] == o_m_tdata[55:51])))
        else $error("packed pixel disagrees with channel fields");

endmodule

bind yuv_to_rgb_color_converter yuv2rgb_checker u_yuv2rgb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> tb/yuv_to_rgb_color_converter_test.sv
module yuv_to_rgb_color_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import yuv2rgb_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } rgb_pixel_t;

    // Holds a private copy of the converter registers and the pixels still owed by the block.
    class rgb_ledger;
        logic [ROW_W-1:0] rows[3];
        logic             luma_ofs;
        t_out_format      fmt;
        rgb_pixel_t       rgb_due[$];
        int               errors;

        function new();
            rows = '{default: '0};
            luma_ofs = 1'b0;
            fmt = FMT_BGRA8888;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            case (idx)
                CFG_RED_ROW:    rows[0] = data;
                CFG_GREEN_ROW:  rows[1] = data;
                CFG_BLUE_ROW:   rows[2] = data;
                CFG_LUMA_OFS:   luma_ofs = data[0];
                CFG_OUT_FORMAT: fmt = t_out_format'(data[0]);
                default: ;
            endcase
        endfunction

        function logic [7:0] mix_channel(logic [ROW_W-1:0] row, int y, int u, int v);
            logic signed [COEF_BITS-1:0] ky;
            logic signed [COEF_BITS-1:0] ku;
            logic signed [COEF_BITS-1:0] kv;
            int                          acc;
            ky = row[COEF_BITS-1:0];
            ku = row[2*COEF_BITS-1:COEF_BITS];
            kv = row[3*COEF_BITS-1:2*COEF_BITS];
            acc = int'(ky) * y + int'(ku) * u + int'(kv) * v + ROUND_BIAS;
            if (acc < 0) begin
                return 8'd0;
            end
            acc = acc >>> FRAC_SHIFT;
            if (acc > 255) begin
                return 8'hff;
            end
            return acc[7:0];
        endfunction

        function void note_pixel(logic [7:0] luma, logic [7:0] cu, logic [7:0] cv);
            rgb_pixel_t px;
            int         y;
            int         u;
            int         v;
            y = int'(luma) - (luma_ofs ? LUMA_BIAS : 0);
            u = int'(cu) - CHROMA_BIAS;
            v = int'(cv) - CHROMA_BIAS;
            px.red   = mix_channel(rows[0], y, u, v);
            px.green = mix_channel(rows[1], y, u, v);
            px.blue  = mix_channel(rows[2], y, u, v);
            if (fmt == FMT_RGB565) begin
                px.word = {16'h0000, px.red[7:3], px.green[7:2], px.blue[7:3]};
            end else begin
                px.word = {ALPHA_OPAQUE, px.red, px.green, px.blue};
            end
            rgb_due.push_back(px);
        endfunction

        function void check_pixel_out(logic [OUT_DATA_W-1:0] data);
            rgb_pixel_t px;
            if (rgb_due.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            px = rgb_due.pop_front();
            if (data[31:0] !== px.word) begin
                $error("packed_pixel: expected %h, got %h", px.word, data[31:0]);
                errors++;
            end
            if (data[39:32] !== px.red) begin
                $error("red: expected %h, got %h", px.red, data[39:32]);
                errors++;
            end
            if (data[47:40] !== px.green) begin
                $error("green: expected %h, got %h", px.green, data[47:40]);
                errors++;
            end
            if (data[55:48] !== px.blue) begin
                $error("blue: expected %h, got %h", px.blue, data[55:48]);
                errors++;
            end
        endfunction

        function int pending();
            return rgb_due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ROW_W-1:0]        cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    rx_ready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;

    rgb_ledger ledger = new();
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        rx_hold_left = 0;

    yuv_to_rgb_color_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (rx_ready),
        .o_m_tdata   (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Result side: check what the block hands over, then pick the ready level for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && rx_ready) begin
            ledger.check_pixel_out(m_tdata);
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [ROW_W-1:0] make_row(int ky, int ku, int kv);
        return {COEF_BITS'(kv), COEF_BITS'(ku), COEF_BITS'(ky)};
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        case ($urandom_range(3))
            0: return {4'($urandom_range(15)), 32'($urandom)};
            1: return make_row(2047, 2047, 2047);
            2: return make_row(-2048, -2048, -2048);
            default: return make_row(int'($urandom_range(1200)) - 600,
                                     int'($urandom_range(1200)) - 600,
                                     int'($urandom_range(1200)) - 600);
        endcase
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        ledger.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One-bit registers get random upper bits, which the block must ignore.
    task automatic write_flag(input logic [CFG_IDX_W-1:0] idx, input logic value);
        write_register(idx, {4'($urandom_range(15)), 31'($urandom), value});
    endtask

    task automatic write_unused_indexes();
        for (int k = int'(CFG_OUT_FORMAT) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_register(CFG_IDX_W'(k), {4'($urandom_range(15)), 32'($urandom)});
        end
    endtask

    task automatic write_matrix(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] g,
                                input logic [ROW_W-1:0] b);
        write_register(CFG_RED_ROW, r);
        write_register(CFG_GREEN_ROW, g);
        write_register(CFG_BLUE_ROW, b);
    endtask

    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cu, input logic [7:0] cv);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cv, cu, luma};
        do @(posedge i_clk); while (!s_tready);
        ledger.note_pixel(luma, cu, cv);
    endtask

    // Stop offering pixels and let every owed result come out before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coefficients still at their reset value: everything is black.
        send_pixel(8'hff, 8'h00, 8'hff);
        send_pixel(8'h00, 8'hff, 8'h00);
        drain();

        // Studio-range BT.601 matrix.
        write_matrix(make_row(596, 0, 817), make_row(596, -201, -416), make_row(596, 1033, 0));
        write_flag(CFG_LUMA_OFS, 1'b1);
        write_flag(CFG_OUT_FORMAT, FMT_BGRA8888);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd16, 8'd128, 8'd128);
        send_pixel(8'd235, 8'd128, 8'd128);
        send_pixel(8'd0, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd255, 8'd0);
        send_pixel(8'd81, 8'd90, 8'd240);
        drain();

        write_flag(CFG_LUMA_OFS, 1'b0);
        write_flag(CFG_OUT_FORMAT, FMT_RGB565);
        write_unused_indexes();
        send_pixel(8'd255, 8'd128, 8'd128);
        send_pixel(8'd0, 8'd128, 8'd128);
        send_pixel(8'd145, 8'd54, 8'd34);
        send_pixel(8'd41, 8'd240, 8'd110);
        send_pixel(8'd170, 8'd166, 8'd16);
        drain();

        // Coefficient extremes drive the sums far past both clamp limits.
        write_matrix(make_row(2047, 2047, 2047), make_row(2047, 2047, 2047),
                     make_row(2047, 2047, 2047));
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
        write_matrix(make_row(-2048, -2048, -2048), make_row(-2048, -2048, -2048),
                     make_row(-2048, -2048, -2048));
        write_flag(CFG_LUMA_OFS, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                tx_idle_pct = 16;
                rx_idle_pct = 79;
            end else if (phase < 4) begin
                tx_idle_pct = 79;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_matrix(random_row(), random_row(), random_row());
            write_flag(CFG_LUMA_OFS, 1'($urandom_range(1)));
            write_flag(CFG_OUT_FORMAT, 1'($urandom_range(1)));
            write_unused_indexes();
            if (phase == 5) begin
                // Long receiver stall while pixels keep coming, so the block backs up.
                rx_hold_left = 300;
            end
            for (int n = 0; n < 188; n++) begin
                send_pixel(random_sample(), random_sample(), random_sample());
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
